@@ hw/rtl/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and tag decode for the class file pool parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int POOL_SLOTS  = 1024;
    localparam int POOL_ADDR_W = $clog2(POOL_SLOTS);
    localparam int NAME_W      = 16;

    // Number of header bytes: magic plus two version words plus pool count
    localparam logic [3:0] HEADER_BYTES = 4'd10;
    localparam logic [3:0] WORD_BYTES   = 4'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_BODY,
        PH_UTF8,
        PH_FLAGS,
        PH_THIS,
        PH_DONE,
        PH_HALT
    } cfp_phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_RECORD  = 2'd2,
        KIND_ERROR   = 2'd3
    } cfp_kind_t;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_TAG  = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELDREF      = 8'd9;
    localparam logic [7:0] TAG_METHODREF     = 8'd10;
    localparam logic [7:0] TAG_IFACEREF      = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE      = 8'd12;
    localparam logic [7:0] TAG_METHODHANDLE  = 8'd15;
    localparam logic [7:0] TAG_METHODTYPE    = 8'd16;
    localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } cfp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] slot;
        logic [7:0]  entry_tag;
        logic [63:0] value_first;
        logic [15:0] value_second;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [15:0] class_flags;
        logic [1:0]  error_code;
    } cfp_out_t;

    // Name table requests from the parser
    typedef struct packed {
        logic                   wr_en;
        logic [POOL_ADDR_W-1:0] wr_addr;
        logic [NAME_W-1:0]      wr_data;
        logic                   rd_en;
        logic [POOL_ADDR_W-1:0] rd_addr;
    } cfp_tbl_req_t;

    // Body length of a tag; zero marks an unknown tag
    function automatic logic [3:0] body_bytes(input logic [7:0] tag);
        logic [3:0] n;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: n = 4'd2;
            TAG_INTEGER, TAG_FLOAT:                          n = 4'd4;
            TAG_LONG, TAG_DOUBLE:                            n = 4'd8;
            TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF,
            TAG_NAMETYPE, TAG_INVOKEDYNAMIC:                 n = 4'd4;
            TAG_METHODHANDLE:                                n = 4'd3;
            default:                                         n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/class_file_const_pool_parser_unit.sv @@
// ----------------------------------------------------------------------------
// class_file_const_pool_parser_unit
// Parses a class file byte stream and reports its constant pool entries.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte of the class file image per request, with
// frame_start marking the first byte of a new file. Output channel m_*: one
// result per pool entry, per utf8 content byte, the final class record, or
// an error. Bytes that complete no field give no result.
// Throughput: one input request per cycle in every phase, unless m_ready stalls.
// A result is registered in the first stage as the byte that causes it is
// accepted, then in the output register; the class record takes its name
// from the registered name table read as it enters the output register.
// The 1024-entry name table RAM is written by Class entries and not cleared
// by reset or frame start; the user, not the block, sees that only slots once
// written are read. Reset clears the parse state and both pipeline stages;
// parsing starts in the header phase. When m_ready is low, the output register
// and the stage behind it fill and s_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module class_file_const_pool_parser_unit
    import cfp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cfp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cfp_out_t m_data
);

    logic             accept, out_free, p1_move;
    logic             res_valid, res_use_table;
    cfp_out_t         res;
    cfp_tbl_req_t     tbl;
    logic [NAME_W-1:0] rd_data;

    cfp_out_t p1_reg, out_reg, out_next;
    logic     p1_use_reg;
    logic     p1_valid_reg, p1_valid_next;
    logic     m_valid_reg, m_valid_next;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    cfp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (accept),
        .in_data       (s_data),
        .res_valid     (res_valid),
        .res           (res),
        .res_use_table (res_use_table),
        .tbl           (tbl)
    );

    cfp_ram #(
        .WIDTH (NAME_W),
        .DEPTH (POOL_SLOTS)
    ) u_name_ram (
        .aclk    (aclk),
        .wr_en   (tbl.wr_en),
        .wr_addr (tbl.wr_addr),
        .wr_data (tbl.wr_data),
        .rd_en   (tbl.rd_en),
        .rd_addr (tbl.rd_addr),
        .rd_data (rd_data)
    );

    // Merge the table read into the record on its way out
    always_comb begin
        out_next = p1_reg;
        if (p1_use_reg) begin
            out_next.value_first = {48'd0, rd_data};
        end
        p1_valid_next = accept ? res_valid : (p1_move ? 1'b0 : p1_valid_reg);
        m_valid_next  = p1_move ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Advance the two result stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= res;
            p1_use_reg <= res_use_table;
        end
        if (p1_move) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A table read is issued only for a class record
    a_read_is_record: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl.rd_en |-> (res_valid && res.kind == KIND_RECORD))
        else $error("name table read outside a class record");

    // A stalled first stage keeps its result
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_free) |=> (p1_valid_reg && $stable(p1_reg)))
        else $error("pending result changed under stall");

    // Error results always carry a code
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_reg.kind == KIND_ERROR) |-> (p1_reg.error_code != ERR_NONE))
        else $error("error result without code");

    // Payload results are tagged as utf8
    a_payload_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_reg.kind == KIND_PAYLOAD) |-> (p1_reg.entry_tag == TAG_UTF8))
        else $error("payload result with wrong tag");

endmodule

@@ hw/rtl/cfp_ram.sv @@
// ----------------------------------------------------------------------------
// cfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cfp_parse.sv @@
// ----------------------------------------------------------------------------
// cfp_parse
// Byte-wise parse state machine: header, pool entries, flags and this_class.
// ----------------------------------------------------------------------------
module cfp_parse
    import cfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  cfp_in_t      in_data,
    output logic         res_valid,
    output cfp_out_t     res,
    output logic         res_use_table,
    output cfp_tbl_req_t tbl
);

    cfp_phase_t  phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  tag_reg, tag_next;
    logic [16:0] slot_reg, slot_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] utf_reg, utf_next;
    logic [15:0] flags_reg, flags_next;

    cfp_phase_t  ph;
    logic [3:0]  fbc, fbc_inc;
    logic [63:0] acc, acc_sh;
    logic [7:0]  tag, b;
    logic [16:0] slot, slot_adv;
    logic [15:0] cnt, utf, flg, t, utf_dec, cnt_new;
    logic        do_adv;
    logic [1:0]  adv_step;

    always_comb begin
        b = in_data.data_byte;
        ph = phase_reg;
        fbc = fbc_reg;
        acc = acc_reg;
        tag = tag_reg;
        slot = slot_reg;
        cnt = count_reg;
        utf = utf_reg;
        flg = flags_reg;
        // Drop the current parse on a frame start
        if (in_data.frame_start) begin
            ph = PH_HEADER;
            fbc = '0;
            acc = '0;
            tag = '0;
            slot = '0;
            cnt = '0;
            utf = '0;
            flg = '0;
        end
        acc_sh = {acc[55:0], b};
        fbc_inc = fbc + 4'd1;
        utf_dec = utf - 16'd1;
        t = acc_sh[15:0];
        cnt_new = (t != 16'd0) ? (t - 16'd1) : 16'd0;

        phase_next = ph;
        fbc_next = fbc;
        acc_next = acc;
        tag_next = tag;
        slot_next = slot;
        count_next = cnt;
        utf_next = utf;
        flags_next = flg;
        res_valid = 1'b0;
        res = '0;
        res_use_table = 1'b0;
        tbl = '0;
        do_adv = 1'b0;
        adv_step = 2'd1;

        case (ph)
            PH_HEADER: begin
                acc_next = acc_sh;
                fbc_next = fbc_inc;
                if (fbc_inc == HEADER_BYTES) begin
                    count_next = cnt_new;
                    slot_next = '0;
                    fbc_next = '0;
                    acc_next = '0;
                    if ({1'b0, cnt_new} > 17'(POOL_SLOTS)) begin
                        phase_next = PH_HALT;
                        res_valid = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_CAPACITY;
                    end else begin
                        phase_next = (cnt_new != 16'd0) ? PH_TAG : PH_FLAGS;
                    end
                end
            end
            PH_TAG: begin
                if (body_bytes(b) == 4'd0) begin
                    phase_next = PH_HALT;
                    res_valid = 1'b1;
                    res.kind = KIND_ERROR;
                    res.slot = slot[15:0];
                    res.entry_tag = b;
                    res.error_code = ERR_BAD_TAG;
                end else begin
                    tag_next = b;
                    fbc_next = '0;
                    acc_next = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                acc_next = acc_sh;
                fbc_next = fbc_inc;
                if (fbc_inc >= body_bytes(tag)) begin
                    res_valid = 1'b1;
                    res.kind = KIND_ENTRY;
                    res.slot = slot[15:0];
                    res.entry_tag = tag;
                    do_adv = 1'b1;
                    case (tag)
                        TAG_UTF8: begin
                            utf_next = acc_sh[15:0];
                            res.value_first = {48'd0, acc_sh[15:0]};
                            if (acc_sh[15:0] != 16'd0) begin
                                do_adv = 1'b0;
                                fbc_next = '0;
                                acc_next = '0;
                                phase_next = PH_UTF8;
                            end
                        end
                        TAG_LONG, TAG_DOUBLE: begin
                            res.value_first = acc_sh;
                            adv_step = 2'd2;
                        end
                        TAG_INTEGER, TAG_FLOAT: begin
                            res.value_first = {32'd0, acc_sh[31:0]};
                        end
                        TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                            res.value_first = {48'd0, acc_sh[15:0]};
                            // Keep class name index per slot
                            if (tag == TAG_CLASS && slot < 17'(POOL_SLOTS)) begin
                                tbl.wr_en = 1'b1;
                                tbl.wr_addr = slot[POOL_ADDR_W-1:0];
                                tbl.wr_data = acc_sh[15:0];
                            end
                        end
                        TAG_METHODHANDLE: begin
                            res.value_first = {56'd0, acc_sh[23:16]};
                            res.value_second = acc_sh[15:0];
                        end
                        default: begin
                            res.value_first = {48'd0, acc_sh[31:16]};
                            res.value_second = acc_sh[15:0];
                        end
                    endcase
                end
            end
            PH_UTF8: begin
                utf_next = utf_dec;
                res_valid = 1'b1;
                res.kind = KIND_PAYLOAD;
                res.slot = slot[15:0];
                res.entry_tag = TAG_UTF8;
                res.payload_byte = b;
                res.payload_last = (utf_dec == 16'd0);
                do_adv = (utf_dec == 16'd0);
            end
            PH_FLAGS: begin
                acc_next = acc_sh;
                fbc_next = fbc_inc;
                if (fbc_inc == WORD_BYTES) begin
                    flags_next = t;
                    fbc_next = '0;
                    acc_next = '0;
                    phase_next = PH_THIS;
                end
            end
            PH_THIS: begin
                acc_next = acc_sh;
                fbc_next = fbc_inc;
                if (fbc_inc == WORD_BYTES) begin
                    fbc_next = '0;
                    acc_next = '0;
                    phase_next = PH_DONE;
                    res_valid = 1'b1;
                    res.kind = KIND_RECORD;
                    res.value_second = t;
                    res.class_flags = flg;
                    // Look up the class name when this_class is in the pool
                    if (t != 16'd0 && t <= cnt && {1'b0, t} <= 17'(POOL_SLOTS)) begin
                        res.slot = t - 16'd1;
                        res_use_table = 1'b1;
                        tbl.rd_en = 1'b1;
                        tbl.rd_addr = cnt_new[POOL_ADDR_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase

        // Advance to the next slot
        slot_adv = slot + {15'd0, adv_step};
        if (do_adv) begin
            slot_next = slot_adv;
            fbc_next = '0;
            acc_next = '0;
            phase_next = (slot_adv >= {1'b0, cnt}) ? PH_FLAGS : PH_TAG;
        end

        // Gate all effects on an accepted request
        if (!in_accept) begin
            res_valid = 1'b0;
            tbl = '0;
        end
    end

    // Hold parse state between requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            fbc_reg <= '0;
            acc_reg <= '0;
            tag_reg <= '0;
            slot_reg <= '0;
            count_reg <= '0;
            utf_reg <= '0;
            flags_reg <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            fbc_reg <= fbc_next;
            acc_reg <= acc_next;
            tag_reg <= tag_next;
            slot_reg <= slot_next;
            count_reg <= count_next;
            utf_reg <= utf_next;
            flags_reg <= flags_next;
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the class file pool parser against an in-bench predictor, using
// directed class file frames followed by random frames with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import cfp_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cfp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cfp_out_t m_data;

    class_file_const_pool_parser_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Predictor state
    cfp_phase_t  phase_q;
    logic [3:0]  nbytes_q;
    logic [63:0] acc_q;
    logic [7:0]  tag_q;
    logic [16:0] slot_q;
    logic [16:0] count_q;
    logic [15:0] utf_left_q;
    logic [15:0] flags_q;
    logic [15:0] names_q [POOL_SLOTS];

    cfp_in_t  byte_q[$];
    cfp_out_t result_q[$];
    int       errors = 0;
    bit       sender_go = 1'b0;
    bit       calm = 1'b0;
    bit       hold_off = 1'b0;
    int       hold_cnt = 0;
    int       idle_cycles = 0;

    function automatic logic [3:0] tag_body_len(input logic [7:0] t);
        case (t)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: return 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACEREF, TAG_NAMETYPE, TAG_INVOKEDYNAMIC:  return 4'd4;
            TAG_LONG, TAG_DOUBLE:                            return 4'd8;
            TAG_METHODHANDLE:                                return 4'd3;
            default:                                         return 4'd0;
        endcase
    endfunction

    function automatic cfp_out_t make_result(input cfp_kind_t k, input logic [15:0] s,
            input logic [7:0] t, input logic [63:0] v1, input logic [15:0] v2,
            input logic [7:0] pb, input logic pl, input logic [15:0] af,
            input logic [1:0] ec);
        cfp_out_t r;
        r.kind = k; r.slot = s; r.entry_tag = t; r.value_first = v1;
        r.value_second = v2; r.payload_byte = pb; r.payload_last = pl;
        r.class_flags = af; r.error_code = ec;
        return r;
    endfunction

    task automatic next_slot(input int step);
        slot_q   = slot_q + 17'(step);
        nbytes_q = 0;
        acc_q    = 0;
        phase_q  = (slot_q >= count_q) ? PH_FLAGS : PH_TAG;
    endtask

    task automatic clear_frame();
        phase_q = PH_HEADER; nbytes_q = 0; acc_q = 0; tag_q = 0;
        slot_q = 0; count_q = 0; utf_left_q = 0; flags_q = 0;
    endtask

    // Advance the parse by one byte and queue any result it produces
    task automatic parse_byte(input cfp_in_t in);
        logic [7:0]  b;
        logic [15:0] t, name;
        logic [15:0] rs;
        b = in.data_byte;
        if (in.frame_start) clear_frame();
        case (phase_q)
            PH_HEADER: begin
                acc_q = {acc_q[55:0], b};
                nbytes_q++;
                if (nbytes_q == HEADER_BYTES) begin
                    t = acc_q[15:0];
                    count_q = (t != 0) ? t - 1 : 0;
                    slot_q = 0; nbytes_q = 0; acc_q = 0;
                    if (count_q > POOL_SLOTS) begin
                        phase_q = PH_HALT;
                        result_q.push_back(make_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0,
                                                       ERR_CAPACITY));
                    end else begin
                        phase_q = (count_q != 0) ? PH_TAG : PH_FLAGS;
                    end
                end
            end
            PH_TAG: begin
                if (tag_body_len(b) == 0) begin
                    phase_q = PH_HALT;
                    result_q.push_back(make_result(KIND_ERROR, slot_q[15:0], b, 0, 0, 0,
                                                   0, 0, ERR_BAD_TAG));
                end else begin
                    tag_q = b; nbytes_q = 0; acc_q = 0; phase_q = PH_BODY;
                end
            end
            PH_BODY: begin
                acc_q = {acc_q[55:0], b};
                nbytes_q++;
                if (nbytes_q == tag_body_len(tag_q)) begin
                    rs = slot_q[15:0];
                    case (tag_q)
                        TAG_UTF8: begin
                            utf_left_q = acc_q[15:0];
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q,
                                               {48'd0, utf_left_q}, 0, 0, 0, 0, ERR_NONE));
                            if (utf_left_q != 0) begin
                                nbytes_q = 0; acc_q = 0; phase_q = PH_UTF8;
                            end else next_slot(1);
                        end
                        TAG_LONG, TAG_DOUBLE: begin
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q, acc_q,
                                               0, 0, 0, 0, ERR_NONE));
                            next_slot(2);
                        end
                        TAG_INTEGER, TAG_FLOAT: begin
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q,
                                               {32'd0, acc_q[31:0]}, 0, 0, 0, 0, ERR_NONE));
                            next_slot(1);
                        end
                        TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
                            if (tag_q == TAG_CLASS && slot_q < POOL_SLOTS)
                                names_q[slot_q[POOL_ADDR_W-1:0]] = acc_q[15:0];
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q,
                                               {48'd0, acc_q[15:0]}, 0, 0, 0, 0, ERR_NONE));
                            next_slot(1);
                        end
                        TAG_METHODHANDLE: begin
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q,
                                               {56'd0, acc_q[23:16]}, acc_q[15:0], 0, 0, 0,
                                               ERR_NONE));
                            next_slot(1);
                        end
                        default: begin
                            result_q.push_back(make_result(KIND_ENTRY, rs, tag_q,
                                               {48'd0, acc_q[31:16]}, acc_q[15:0], 0, 0, 0,
                                               ERR_NONE));
                            next_slot(1);
                        end
                    endcase
                end
            end
            PH_UTF8: begin
                utf_left_q--;
                result_q.push_back(make_result(KIND_PAYLOAD, slot_q[15:0], TAG_UTF8, 0, 0, b,
                                               utf_left_q == 0, 0, ERR_NONE));
                if (utf_left_q == 0) next_slot(1);
            end
            PH_FLAGS: begin
                acc_q = {acc_q[55:0], b};
                nbytes_q++;
                if (nbytes_q == WORD_BYTES) begin
                    flags_q = acc_q[15:0]; nbytes_q = 0; acc_q = 0; phase_q = PH_THIS;
                end
            end
            PH_THIS: begin
                acc_q = {acc_q[55:0], b};
                nbytes_q++;
                if (nbytes_q == WORD_BYTES) begin
                    t = acc_q[15:0]; name = 0; rs = 0;
                    if (t >= 1 && t <= count_q && t - 1 < POOL_SLOTS) begin
                        rs = t - 1; name = names_q[rs[POOL_ADDR_W-1:0]];
                    end
                    nbytes_q = 0; acc_q = 0; phase_q = PH_DONE;
                    result_q.push_back(make_result(KIND_RECORD, rs, 0, {48'd0, name}, t, 0,
                                                   0, flags_q, ERR_NONE));
                end
            end
            default: ;
        endcase
    endtask

    // Frame builder: bytes go to the pending queue, class slots remembered
    bit          class_at [int];
    cfp_in_t     frame_q[$];

    task automatic put_byte(input logic [7:0] b);
        cfp_in_t x;
        x.data_byte = b;
        x.frame_start = (frame_q.size() == 0);
        frame_q.push_back(x);
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endtask

    task automatic random_body(input logic [7:0] t, input int utf_max);
        int n;
        if (t == TAG_UTF8) begin
            n = $urandom_range(utf_max, 0);
            put_word(n[15:0]);
            repeat (n) put_byte(8'($urandom));
        end else begin
            repeat (tag_body_len(t)) put_byte(8'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_tag();
        logic [7:0] tags [14] = '{TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE,
            TAG_CLASS, TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IFACEREF, TAG_NAMETYPE,
            TAG_METHODHANDLE, TAG_METHODTYPE, TAG_INVOKEDYNAMIC};
        return tags[$urandom_range(13, 0)];
    endfunction

    // Build one well-formed frame of n slots; this_class names a Class slot or
    // is out of range, so that no unwritten name is read
    task automatic well_formed_frame(input int nslots, input int utf_max);
        int s, pick, tries;
        logic [7:0] t;
        logic [15:0] this_idx;
        frame_q.delete();
        class_at.delete();
        repeat (4) put_byte(8'($urandom));
        put_word(16'($urandom));
        put_word(16'($urandom));
        put_word(16'(nslots + 1));
        s = 0;
        while (s < nslots) begin
            t = pick_tag();
            if ((t == TAG_LONG || t == TAG_DOUBLE) && $urandom_range(1, 0)) t = TAG_CLASS;
            put_byte(t);
            if (t == TAG_CLASS) begin
                class_at[s] = 1'b1;
                put_word(16'($urandom));
            end else random_body(t, utf_max);
            s += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
        end
        put_word(16'($urandom));
        this_idx = 0;
        if (class_at.num() > 0 && $urandom_range(9, 0) != 0) begin
            pick = $urandom_range(class_at.num() - 1, 0);
            tries = 0;
            foreach (class_at[k]) begin
                if (tries == pick) this_idx = 16'(k + 1);
                tries++;
            end
        end else if ($urandom_range(1, 0)) begin
            this_idx = 16'(nslots + 1 + $urandom_range(100, 0));
        end
        put_word(this_idx);
    endtask

    // Queue a frame; trailing filler follows only a complete frame
    task automatic commit_frame(input int cut);
        int n;
        n = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
        for (int i = 0; i < n; i++) byte_q.push_back(frame_q[i]);
        if (n == frame_q.size())
            repeat ($urandom_range(3, 0)) byte_q.push_back(cfp_in_t'({8'($urandom), 1'b0}));
    endtask

    // Driver: present the next request, hold it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sender_go && byte_q.size() > 0 && (calm || $urandom_range(99, 0) >= 26)) begin
                s_valid <= 1'b1;
                s_data  <= byte_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted request
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) parse_byte(s_data);
    end

    // Receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_off && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99, 0) >= 26);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        cfp_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result kind=%0d slot=%0d", m_data.kind, m_data.slot);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_data.kind != e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, m_data.kind); errors++;
                end
                if (m_data.slot != e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, m_data.slot); errors++;
                end
                if (m_data.entry_tag != e.entry_tag) begin
                    $error("entry_tag exp %0d got %0d", e.entry_tag, m_data.entry_tag);
                    errors++;
                end
                if (m_data.value_first != e.value_first) begin
                    $error("value_first exp %h got %h", e.value_first, m_data.value_first);
                    errors++;
                end
                if (m_data.value_second != e.value_second) begin
                    $error("value_second exp %h got %h", e.value_second, m_data.value_second);
                    errors++;
                end
                if (m_data.payload_byte != e.payload_byte) begin
                    $error("payload_byte exp %h got %h", e.payload_byte, m_data.payload_byte);
                    errors++;
                end
                if (m_data.payload_last != e.payload_last) begin
                    $error("payload_last exp %0d got %0d", e.payload_last, m_data.payload_last);
                    errors++;
                end
                if (m_data.class_flags != e.class_flags) begin
                    $error("class_flags exp %h got %h", e.class_flags, m_data.class_flags);
                    errors++;
                end
                if (m_data.error_code != e.error_code) begin
                    $error("error_code exp %0d got %0d", e.error_code, m_data.error_code);
                    errors++;
                end
            end
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int total;
        logic [7:0] bad;
        clear_frame();
        for (int i = 0; i < POOL_SLOTS; i++) names_q[i] = 0;

        // Directed: empty pool with this_class zero, then a random 16-slot frame
        frame_q.delete();
        repeat (4) put_byte(8'hFF);
        put_word(16'h0000); put_word(16'hFFFF);
        put_word(16'd0);                     // empty pool
        put_word(16'hFFFF); put_word(16'd0); // this_class zero
        commit_frame(0);
        well_formed_frame(16, 3);
        commit_frame(0);
        // Abandoned frame, then pool too large
        well_formed_frame(6, 2);
        commit_frame(9);
        frame_q.delete();
        repeat (8) put_byte(8'h00);
        put_word(16'hFFFF);
        put_byte(8'hAA); put_byte(8'h55);    // ignored after error
        commit_frame(0);
        // Unknown tag
        frame_q.delete();
        repeat (8) put_byte(8'h00);
        put_word(16'd3);
        put_byte(TAG_CLASS); put_word(16'hFFFF);
        put_byte(8'd2);
        commit_frame(0);
        // Largest pool that fits passes the capacity check, then is abandoned
        frame_q.delete();
        repeat (8) put_byte(8'h00);
        put_word(16'(POOL_SLOTS + 1));
        for (int s = 0; s < 12; s++) begin
            put_byte(TAG_CLASS); put_word(s[15:0]);
        end
        commit_frame(30);
        // Long entry in the last slot
        frame_q.delete();
        repeat (8) put_byte(8'h00);
        put_word(16'd4);
        put_byte(TAG_CLASS); put_word(16'h1234);
        put_byte(TAG_LONG); repeat (8) put_byte(8'hFF);
        put_word(16'h8001); put_word(16'd1);
        commit_frame(0);

        // Random: mostly well-formed frames, some broken ones
        total = byte_q.size();
        while (total < 1300) begin
            well_formed_frame($urandom_range(8, 1), 5);
            case ($urandom_range(9, 0))
                0: commit_frame($urandom_range(frame_q.size() - 1, 1));
                1: begin
                    bad = $urandom;
                    if (tag_body_len(bad) == 0) frame_q.insert(10, cfp_in_t'({bad, 1'b0}));
                    commit_frame(0);
                end
                default: commit_frame(0);
            endcase
            total = byte_q.size();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_go <= 1'b1;
        // Long receiver hold-off while requests keep coming
        repeat (50) @(posedge aclk);
        hold_off <= 1'b1;
        wait (hold_cnt >= 400);
        hold_off <= 1'b0;
        calm <= 1'b1;
        repeat (300) @(posedge aclk);
        calm <= 1'b0;

        wait (byte_q.size() == 0 && !s_valid);
        wait (result_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ class_file_const_pool_parser_unit.f @@
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_ram.sv
hw/rtl/cfp_parse.sv
hw/rtl/class_file_const_pool_parser_unit.sv
tb/tb.sv
